// File: hw/rtl/lrufr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LRU frame replacer package
// Request codes and the control word passed from the list update logic.
// ----------------------------------------------------------------------------
package lrufr_pkg;

	localparam int OPCODE_W = 2;
	localparam int FRAME_W  = 6;
	localparam int COUNT_W  = 7;

	// request kinds; the fourth code is unused and changes nothing
	typedef enum logic [OPCODE_W-1:0] {
		OP_VICTIM = 2'd0,
		OP_PIN    = 2'd1,
		OP_UNPIN  = 2'd2
	} op_t;

	// what the update logic decided for the item in stage 1
	typedef struct packed {
		logic take;   // frame leaves the set
		logic put;    // frame joins the set at the newest end
		logic ok;     // successful victim
	} upd_ctrl_t;

endpackage

// File: hw/rtl/lrufr_req_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LRU frame replacer request channel
// valid/ready channel carrying one request per transfer.
// ----------------------------------------------------------------------------
interface lrufr_req_if;
	import lrufr_pkg::*;

	logic                valid;
	logic                ready;
	logic [OPCODE_W-1:0] opcode;
	logic [FRAME_W-1:0]  frame_index;

	modport source (output valid, output opcode, output frame_index, input ready);
	modport sink   (input valid, input opcode, input frame_index, output ready);

endinterface

// File: hw/rtl/lrufr_rsp_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LRU frame replacer response channel
// valid/ready channel carrying one result per transfer.
// ----------------------------------------------------------------------------
interface lrufr_rsp_if;
	import lrufr_pkg::*;

	logic               valid;
	logic               ready;
	logic               ok;
	logic [FRAME_W-1:0] victim_frame;
	logic [COUNT_W-1:0] evictable_now;

	modport source (output valid, output ok, output victim_frame, output evictable_now,
		input ready);
	modport sink   (input valid, input ok, input victim_frame, input evictable_now,
		output ready);

endinterface

// File: hw/rtl/lru_frame_replacer_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LRU frame replacer
// Ordered set of evictable buffer-pool frames kept as a doubly linked list.
// ----------------------------------------------------------------------------
// Takes one request per clock cycle while the response side is not stalled.
// A transferred request is held in the stage 1 register while both link
// memories are read for its frame; then the list update is applied and the
// result register is loaded, from which the result is offered. The
// sustained rate of one request per cycle is set by the update around the
// link memories' read port, whose address for a victim request comes from
// the oldest-frame pointer after the preceding request, with write-to-read
// forwarding inside each memory. Membership flags sit in flip-flops cleared
// by reset, so there is no clearing pass. Frames at or above NUM_FRAMES are
// ignored by pin and unpin.
// ----------------------------------------------------------------------------
module lru_frame_replacer_top
	import lrufr_pkg::*;
#(
	parameter int NUM_FRAMES = 64
) (
	input  logic         clk,
	input  logic         arst_n,
	lrufr_req_if.sink    req,
	lrufr_rsp_if.source  rsp
);

	localparam int IDX_W = $clog2(NUM_FRAMES);
	localparam int CNT_W = $clog2(NUM_FRAMES + 1);

	// stage 1 request register
	logic               valid_s1;
	op_t                op_s1;
	logic [FRAME_W-1:0] frame_s1;

	// list state
	logic [NUM_FRAMES-1:0] member_q;
	logic [IDX_W-1:0]      newest_q;
	logic [IDX_W-1:0]      oldest_q;
	logic [CNT_W-1:0]      count_q;

	// result register
	logic               rsp_valid_q;
	logic               ok_q;
	logic [FRAME_W-1:0] victim_q;
	logic [COUNT_W-1:0] count_out_q;

	// update outputs
	upd_ctrl_t          ctrl;
	logic [IDX_W-1:0]   sel;
	logic [IDX_W-1:0]   newest_n;
	logic [IDX_W-1:0]   oldest_n;
	logic [CNT_W-1:0]   count_n;
	logic               newer_we;
	logic [IDX_W-1:0]   newer_addr;
	logic [IDX_W-1:0]   newer_data;
	logic               older_we;
	logic [IDX_W-1:0]   older_addr;
	logic [IDX_W-1:0]   older_data;
	logic [FRAME_W-1:0] victim_n;
	logic [COUNT_W-1:0] evictable_n;
	logic [IDX_W-1:0]   up;
	logic [IDX_W-1:0]   down;

	logic               adv;
	logic               req_xfer;
	logic [IDX_W-1:0]   oldest_next;
	logic [IDX_W-1:0]   rd_addr;

	// handshake: stage 1 moves on when the result register is free
	assign adv       = valid_s1 && (!rsp_valid_q || rsp.ready);
	assign req.ready = !valid_s1 || adv;
	assign req_xfer  = req.valid && req.ready;

	// read address sees the list after the request now in stage 1
	assign oldest_next = adv ? oldest_n : oldest_q;
	assign rd_addr     = (req.opcode == OP_VICTIM) ? oldest_next : IDX_W'(req.frame_index);

	lrufr_link_ram #(
		.DEPTH (NUM_FRAMES),
		.WIDTH (IDX_W)
	) u_newer_ram (
		.clk       (clk),
		.rd_en     (req_xfer),
		.rd_addr   (rd_addr),
		.rd_data_q (up),
		.wr_en     (adv && newer_we),
		.wr_addr   (newer_addr),
		.wr_data   (newer_data)
	);

	lrufr_link_ram #(
		.DEPTH (NUM_FRAMES),
		.WIDTH (IDX_W)
	) u_older_ram (
		.clk       (clk),
		.rd_en     (req_xfer),
		.rd_addr   (rd_addr),
		.rd_data_q (down),
		.wr_en     (adv && older_we),
		.wr_addr   (older_addr),
		.wr_data   (older_data)
	);

	lrufr_update #(
		.NUM_FRAMES (NUM_FRAMES)
	) u_update (
		.op            (op_s1),
		.frame         (frame_s1),
		.member        (member_q),
		.newest        (newest_q),
		.oldest        (oldest_q),
		.count         (count_q),
		.up            (up),
		.down          (down),
		.ctrl          (ctrl),
		.sel           (sel),
		.newest_n      (newest_n),
		.oldest_n      (oldest_n),
		.count_n       (count_n),
		.newer_we      (newer_we),
		.newer_addr    (newer_addr),
		.newer_data    (newer_data),
		.older_we      (older_we),
		.older_addr    (older_addr),
		.older_data    (older_data),
		.victim_frame  (victim_n),
		.evictable_now (evictable_n)
	);

	// stage 1 request register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req.ready) begin
			valid_s1 <= req.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req_xfer) begin
			op_s1    <= op_t'(req.opcode);
			frame_s1 <= req.frame_index;
		end
	end

	// list head, tail, count and membership
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			member_q <= '0;
			newest_q <= '0;
			oldest_q <= '0;
			count_q  <= '0;
		end else if (adv) begin
			if (ctrl.take) begin
				member_q[sel] <= 1'b0;
			end else if (ctrl.put) begin
				member_q[sel] <= 1'b1;
			end
			newest_q <= newest_n;
			oldest_q <= oldest_n;
			count_q  <= count_n;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (adv) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			ok_q        <= ctrl.ok;
			victim_q    <= victim_n;
			count_out_q <= evictable_n;
		end
	end

	assign rsp.valid         = rsp_valid_q;
	assign rsp.ok            = ok_q;
	assign rsp.victim_frame  = victim_q;
	assign rsp.evictable_now = count_out_q;

endmodule

// File: hw/rtl/lrufr_link_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LRU frame replacer link memory
// One write port, one registered read port; a read of the address being
// written in the same cycle returns the new data.
// ----------------------------------------------------------------------------
module lrufr_link_ram #(
	parameter int DEPTH = 64,
	parameter int WIDTH = 6
) (
	input  logic                     clk,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data_q,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write, and read with write-first forwarding
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			if (wr_en && (wr_addr == rd_addr)) begin
				rd_data_q <= wr_data;
			end else begin
				rd_data_q <= mem_q[rd_addr];
			end
		end
	end

endmodule

// File: hw/rtl/lrufr_update.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LRU frame replacer list update
// Next head, tail, count and link writes for the request held in stage 1.
// ----------------------------------------------------------------------------
module lrufr_update
	import lrufr_pkg::*;
#(
	parameter int NUM_FRAMES = 64
) (
	input  op_t                                   op,
	input  logic [FRAME_W-1:0]                    frame,
	input  logic [NUM_FRAMES-1:0]                 member,
	input  logic [$clog2(NUM_FRAMES)-1:0]         newest,
	input  logic [$clog2(NUM_FRAMES)-1:0]         oldest,
	input  logic [$clog2(NUM_FRAMES+1)-1:0]       count,
	input  logic [$clog2(NUM_FRAMES)-1:0]         up,      // newer neighbour of frame
	input  logic [$clog2(NUM_FRAMES)-1:0]         down,    // older neighbour of frame
	output upd_ctrl_t                             ctrl,
	output logic [$clog2(NUM_FRAMES)-1:0]         sel,
	output logic [$clog2(NUM_FRAMES)-1:0]         newest_n,
	output logic [$clog2(NUM_FRAMES)-1:0]         oldest_n,
	output logic [$clog2(NUM_FRAMES+1)-1:0]       count_n,
	output logic                                  newer_we,
	output logic [$clog2(NUM_FRAMES)-1:0]         newer_addr,
	output logic [$clog2(NUM_FRAMES)-1:0]         newer_data,
	output logic                                  older_we,
	output logic [$clog2(NUM_FRAMES)-1:0]         older_addr,
	output logic [$clog2(NUM_FRAMES)-1:0]         older_data,
	output logic [FRAME_W-1:0]                    victim_frame,
	output logic [COUNT_W-1:0]                    evictable_now
);

	localparam int IDX_W = $clog2(NUM_FRAMES);
	localparam int CNT_W = $clog2(NUM_FRAMES + 1);

	logic is_victim;
	logic is_pin;
	logic is_unpin;
	logic in_range;
	logic nonempty;

	// request decode and membership check
	always_comb begin
		is_victim = (op == OP_VICTIM);
		is_pin    = (op == OP_PIN);
		is_unpin  = (op == OP_UNPIN);
		in_range  = (32'(frame) < NUM_FRAMES);
		nonempty  = (count != '0);
		sel       = is_victim ? oldest : IDX_W'(frame);
		ctrl.ok   = is_victim && nonempty;
		ctrl.take = ctrl.ok || (is_pin && in_range && member[sel]);
		ctrl.put  = is_unpin && in_range && !member[sel];
	end

	// unlink or append; links of the newest frame's newer side and the
	// oldest frame's older side are never followed, so they are not kept
	always_comb begin
		newest_n   = newest;
		oldest_n   = oldest;
		count_n    = count;
		newer_we   = 1'b0;
		newer_addr = down;
		newer_data = up;
		older_we   = 1'b0;
		older_addr = up;
		older_data = down;
		if (ctrl.take) begin
			if (count <= CNT_W'(1)) begin
				newest_n = '0;
				oldest_n = '0;
			end else if (sel == newest) begin
				newest_n = down;
			end else if (sel == oldest) begin
				oldest_n = up;
			end else begin
				newer_we = 1'b1;
				older_we = 1'b1;
			end
			count_n = count - CNT_W'(1);
		end else if (ctrl.put) begin
			if (!nonempty) begin
				newest_n = sel;
				oldest_n = sel;
			end else begin
				older_we   = 1'b1;
				older_addr = sel;
				older_data = newest;
				newer_we   = 1'b1;
				newer_addr = newest;
				newer_data = sel;
				newest_n   = sel;
			end
			count_n = count + CNT_W'(1);
		end
	end

	// result fields
	assign victim_frame  = ctrl.ok ? FRAME_W'(sel) : '0;
	assign evictable_now = COUNT_W'(count_n);

endmodule

// File: hw/rtl/lrufr_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LRU frame replacer port checker
// Checks result consistency and response channel behaviour at the ports.
// ----------------------------------------------------------------------------
module lrufr_port_props
	import lrufr_pkg::*;
(
	input logic               clk,
	input logic               arst_n,
	input logic               rsp_valid,
	input logic               rsp_ready,
	input logic               ok,
	input logic [FRAME_W-1:0] victim_frame,
	input logic [COUNT_W-1:0] evictable_now
);

	// no eviction, no frame number
	a_victim_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && !ok) |-> (victim_frame == '0))
		else $error("victim_frame non-zero without eviction");

	// a successful victim leaves fewer frames than the set can hold
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> ((evictable_now <= 7'd64) && (!ok || (evictable_now <= 7'd63))))
		else $error("evictable count out of range");

	// consecutive results: count moves by at most one, and down after an eviction
	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && rsp_ready) ##1 rsp_valid |->
			((evictable_now == $past(evictable_now)) ||
			 (evictable_now == $past(evictable_now) + 7'd1) ||
			 (evictable_now + 7'd1 == $past(evictable_now))) &&
			(!ok || (evictable_now + 7'd1 == $past(evictable_now))))
		else $error("evictable count jumped between results");

	// a stalled result holds
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && !rsp_ready) |=>
			(rsp_valid && $stable(ok) && $stable(victim_frame) && $stable(evictable_now)))
		else $error("stalled result changed");

endmodule

bind lru_frame_replacer_top lrufr_port_props u_lrufr_port_props (
	.clk           (clk),
	.arst_n        (arst_n),
	.rsp_valid     (rsp.valid),
	.rsp_ready     (rsp.ready),
	.ok            (rsp.ok),
	.victim_frame  (rsp.victim_frame),
	.evictable_now (rsp.evictable_now)
);

// File: sim/lrufr_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LRU frame replacer checker
// Watches the request and response channels. It keeps its own copy of the
// eviction order, predicts the result of every request transfer and compares
// each response transfer field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module lrufr_checker
	import lrufr_pkg::*;
#(
	parameter int NUM_FRAMES = 64
) (
	input  logic clk,
	input  logic arst_n,
	lrufr_req_if req,
	lrufr_rsp_if rsp,
	output int   fail_count,
	output int   pending,
	output int   request_count,
	output int   eviction_count,
	output int   empty_victims,
	output int   peak_size
);

	typedef struct packed {
		logic               ok;
		logic [FRAME_W-1:0] victim_frame;
		logic [COUNT_W-1:0] evictable_now;
	} lru_result_t;

	// predicted eviction order: membership, links towards both ends, end pointers
	logic [NUM_FRAMES-1:0] in_set;
	logic [FRAME_W-1:0]    newer_of [NUM_FRAMES];
	logic [FRAME_W-1:0]    older_of [NUM_FRAMES];
	logic [FRAME_W-1:0]    newest;
	logic [FRAME_W-1:0]    oldest;
	logic [COUNT_W-1:0]    set_size;

	lru_result_t awaited_results [$];
	int          fails;
	int          requests;
	int          evictions;
	int          empties;
	int          peak;

	function automatic void clear_order();
		in_set   = '0;
		newest   = '0;
		oldest   = '0;
		set_size = '0;
		for (int i = 0; i < NUM_FRAMES; i++) begin
			newer_of[i] = '0;
			older_of[i] = '0;
		end
	endfunction

	// remove a member frame and stitch its neighbours together
	function automatic void unlink_frame(input logic [FRAME_W-1:0] frame);
		logic [FRAME_W-1:0] up;
		logic [FRAME_W-1:0] down;
		bit                 is_newest;
		bit                 is_oldest;
		up        = newer_of[frame];
		down      = older_of[frame];
		is_newest = (frame == newest);
		is_oldest = (frame == oldest);
		if (set_size <= 1) begin
			newest = '0;
			oldest = '0;
		end else if (is_newest) begin
			newest = down;
		end else if (is_oldest) begin
			oldest = up;
		end else begin
			older_of[up]   = down;
			newer_of[down] = up;
		end
		// the new end points at itself
		if (is_newest && !is_oldest && set_size > 1)
			newer_of[down] = down;
		if (is_oldest && !is_newest && set_size > 1)
			older_of[up] = up;
		in_set[frame] = 1'b0;
		if (set_size > 0)
			set_size = set_size - 1'b1;
	endfunction

	// append an absent frame at the newest end
	function automatic void append_newest(input logic [FRAME_W-1:0] frame);
		if (set_size == 0) begin
			newest          = frame;
			oldest          = frame;
			newer_of[frame] = frame;
			older_of[frame] = frame;
		end else begin
			older_of[frame]  = newest;
			newer_of[frame]  = frame;
			newer_of[newest] = frame;
			newest           = frame;
		end
		in_set[frame] = 1'b1;
		set_size      = set_size + 1'b1;
	endfunction

	// apply one request to the predicted order and return its result
	function automatic lru_result_t predict_result(input logic [OPCODE_W-1:0] opcode,
		input logic [FRAME_W-1:0] frame);
		lru_result_t res;
		res = '0;
		case (opcode)
			OP_VICTIM: begin
				if (set_size > 0) begin
					res.ok           = 1'b1;
					res.victim_frame = oldest;
					unlink_frame(oldest);
					evictions++;
				end else begin
					empties++;
				end
			end
			OP_PIN: begin
				if (frame < NUM_FRAMES && in_set[frame])
					unlink_frame(frame);
			end
			OP_UNPIN: begin
				if (frame < NUM_FRAMES && !in_set[frame])
					append_newest(frame);
			end
			default: ;
		endcase
		res.evictable_now = set_size;
		if (set_size > peak)
			peak = set_size;
		return res;
	endfunction

	task automatic report_mismatch(input string what, input int got, input int wanted);
		$display("MISMATCH at %0t ns: %s got %0d expected %0d", $time, what, got, wanted);
		fails++;
	endtask

	// sample both channels at each rising edge
	always @(posedge clk or negedge arst_n) begin : watch
		lru_result_t want;
		if (!arst_n) begin
			clear_order();
			awaited_results.delete();
			fails     = 0;
			requests  = 0;
			evictions = 0;
			empties   = 0;
			peak      = 0;
		end else begin
			if (rsp.valid && rsp.ready) begin
				if (awaited_results.size() == 0) begin
					report_mismatch("result transfer with nothing outstanding",
						rsp.evictable_now, -1);
				end else begin
					want = awaited_results.pop_front();
					if (rsp.ok !== want.ok)
						report_mismatch("ok", rsp.ok, want.ok);
					if (rsp.victim_frame !== want.victim_frame)
						report_mismatch("victim_frame", rsp.victim_frame, want.victim_frame);
					if (rsp.evictable_now !== want.evictable_now)
						report_mismatch("evictable_now", rsp.evictable_now,
							want.evictable_now);
				end
			end
			if (req.valid && req.ready) begin
				awaited_results.push_back(predict_result(req.opcode, req.frame_index));
				requests++;
			end
		end
		fail_count     <= fails;
		pending        <= awaited_results.size();
		request_count  <= requests;
		eviction_count <= evictions;
		empty_victims  <= empties;
		peak_size      <= peak;
	end

endmodule

// File: sim/lru_frame_replacer_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LRU frame replacer testbench
// Drives directed and random pin, unpin and victim requests in bursts with
// random gaps, stalls the response side on its own pattern, and leaves all
// prediction and comparison to the checker beside the block.
// ----------------------------------------------------------------------------
module lru_frame_replacer_top_tb;
	import lrufr_pkg::*;

	localparam int NUM_FRAMES   = 64;
	localparam int CLK_HALF     = 6;
	localparam int RANDOM_ITEMS = 1750;
	localparam int CYCLE_LIMIT  = 200000;
	localparam int SETTLE       = 6;

	// the fourth request code is unused by the block
	localparam logic [OPCODE_W-1:0] OP_UNUSED = 2'd3;

	typedef enum int {SEQ_FILL, SEQ_DRAIN, SEQ_MIXED, SEQ_SWEEP, SEQ_NOISE} seq_kind_t;
	typedef enum int {SINK_OPEN, SINK_BURSTY, SINK_COIN} sink_mode_t;

	logic clk;
	logic arst_n;

	lrufr_req_if req_ch();
	lrufr_rsp_if rsp_ch();

	int fail_count;
	int pending;
	int request_count;
	int eviction_count;
	int empty_victims;
	int peak_size;

	int         burst_left  = 0;
	int         random_sent = 0;
	int         cycles      = 0;
	sink_mode_t sink_mode   = SINK_OPEN;
	int         mode_left   = 0;
	int         stall_left  = 0;

	lru_frame_replacer_top #(
		.NUM_FRAMES (NUM_FRAMES)
	) dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	lrufr_checker #(
		.NUM_FRAMES (NUM_FRAMES)
	) u_checker (
		.clk            (clk),
		.arst_n         (arst_n),
		.req            (req_ch),
		.rsp            (rsp_ch),
		.fail_count     (fail_count),
		.pending        (pending),
		.request_count  (request_count),
		.eviction_count (eviction_count),
		.empty_victims  (empty_victims),
		.peak_size      (peak_size)
	);

	initial begin
		clk = 1'b0;
		forever #CLK_HALF clk = ~clk;
	end

	// watchdog
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles, %0d results outstanding", cycles, pending);
			$display("CHECKS FAILED");
			$finish;
		end
	end

	// response back-pressure: modes of random length, some with no stalls at all
	always @(negedge clk) begin
		if (mode_left == 0) begin
			sink_mode = sink_mode_t'($urandom_range(0, 2));
			mode_left = $urandom_range(20, 150);
		end
		mode_left--;
		if (stall_left > 0) begin
			stall_left--;
			rsp_ch.ready <= 1'b0;
		end else begin
			case (sink_mode)
				SINK_OPEN: rsp_ch.ready <= 1'b1;
				SINK_BURSTY: begin
					if ($urandom_range(0, 4) == 0) begin
						stall_left = $urandom_range(0, 5);
						rsp_ch.ready <= 1'b0;
					end else begin
						rsp_ch.ready <= 1'b1;
					end
				end
				default: rsp_ch.ready <= 1'($urandom_range(0, 1));
			endcase
		end
	end

	// one request transfer; the sender idles between bursts
	task automatic send_request(input logic [OPCODE_W-1:0] op, input logic [FRAME_W-1:0] frame);
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 7) == 0) ? $urandom_range(5, 14) : $urandom_range(0, 3);
			repeat (gap) begin
				@(negedge clk);
				req_ch.valid <= 1'b0;
			end
			burst_left = $urandom_range(1, 30);
		end
		burst_left--;
		@(negedge clk);
		req_ch.valid       <= 1'b1;
		req_ch.opcode      <= op;
		req_ch.frame_index <= frame;
		do @(posedge clk); while (!req_ch.ready);
	endtask

	// hold off until every outstanding result has been transferred
	task automatic wait_drained();
		@(negedge clk);
		req_ch.valid <= 1'b0;
		do @(posedge clk); while (pending != 0);
	endtask

	function automatic logic [OPCODE_W-1:0] choose_op(input seq_kind_t kind);
		int roll;
		roll = $urandom_range(0, 99);
		case (kind)
			SEQ_FILL:
				return (roll < 70) ? OP_UNPIN : (roll < 85) ? OP_PIN :
					(roll < 97) ? OP_VICTIM : OP_UNUSED;
			SEQ_DRAIN:
				return (roll < 50) ? OP_VICTIM : (roll < 80) ? OP_PIN :
					(roll < 97) ? OP_UNPIN : OP_UNUSED;
			SEQ_MIXED:
				return (roll < 35) ? OP_UNPIN : (roll < 65) ? OP_PIN :
					(roll < 95) ? OP_VICTIM : OP_UNUSED;
			default:
				return OPCODE_W'($urandom_range(0, 3));
		endcase
	endfunction

	// a narrow window of frames makes repeats and present-frame hits common
	task automatic run_sequence(input seq_kind_t kind, input int len);
		int                 order [NUM_FRAMES];
		int                 j;
		int                 tmp;
		int                 base;
		bit                 narrow;
		logic [FRAME_W-1:0] frame;
		narrow = (kind != SEQ_NOISE) && ($urandom_range(0, 1) == 1);
		base   = $urandom_range(0, NUM_FRAMES - 8);
		if (kind == SEQ_SWEEP) begin
			// every frame in random order fills the set, then pins and victims take frames out
			for (int i = 0; i < NUM_FRAMES; i++)
				order[i] = i;
			for (int i = NUM_FRAMES - 1; i > 0; i--) begin
				j        = $urandom_range(0, i);
				tmp      = order[i];
				order[i] = order[j];
				order[j] = tmp;
			end
			for (int i = 0; i < NUM_FRAMES; i++)
				send_request(OP_UNPIN, FRAME_W'(order[i]));
			send_request(OP_UNUSED, FRAME_W'($urandom_range(0, NUM_FRAMES - 1)));
			send_request(OP_UNPIN, FRAME_W'(order[$urandom_range(0, NUM_FRAMES - 1)]));
			for (int i = 0; i < len; i++) begin
				send_request(($urandom_range(0, 3) == 0) ? OP_PIN : OP_VICTIM,
					FRAME_W'($urandom_range(0, NUM_FRAMES - 1)));
			end
			random_sent += NUM_FRAMES + 2 + len;
		end else begin
			for (int i = 0; i < len; i++) begin
				frame = narrow ? FRAME_W'(base + $urandom_range(0, 7)) :
					FRAME_W'($urandom_range(0, NUM_FRAMES - 1));
				send_request(choose_op(kind), frame);
			end
			random_sent += len;
		end
	endtask

	initial begin
		arst_n             = 1'b0;
		req_ch.valid       = 1'b0;
		req_ch.opcode      = OP_VICTIM;
		req_ch.frame_index = '0;
		rsp_ch.ready       = 1'b0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// directed: empty set, repeats, pins at each position, unused code
		send_request(OP_VICTIM, 6'd0);
		send_request(OP_UNUSED, 6'd63);
		send_request(OP_PIN, 6'd5);
		send_request(OP_UNPIN, 6'd0);
		send_request(OP_UNPIN, 6'd63);
		send_request(OP_UNPIN, 6'd0);
		send_request(OP_UNPIN, 6'd21);
		send_request(OP_UNPIN, 6'd42);
		send_request(OP_PIN, 6'd5);
		send_request(OP_PIN, 6'd21);
		send_request(OP_PIN, 6'd42);
		send_request(OP_UNPIN, 6'd1);
		send_request(OP_PIN, 6'd0);
		send_request(OP_UNUSED, 6'd63);
		send_request(OP_VICTIM, 6'd63);
		send_request(OP_VICTIM, 6'd0);
		send_request(OP_VICTIM, 6'd0);
		send_request(OP_UNPIN, 6'd63);
		send_request(OP_PIN, 6'd63);
		send_request(OP_UNPIN, 6'd7);
		send_request(OP_UNPIN, 6'd9);
		send_request(OP_UNPIN, 6'd7);
		send_request(OP_VICTIM, 6'd0);
		send_request(OP_VICTIM, 6'd0);
		send_request(OP_VICTIM, 6'd0);
		wait_drained();

		// random sequences with occasional full drains
		while (random_sent < RANDOM_ITEMS) begin
			run_sequence(seq_kind_t'($urandom_range(0, 4)), $urandom_range(10, 60));
			if ($urandom_range(0, 9) == 0)
				wait_drained();
		end
		wait_drained();
		repeat (SETTLE) @(posedge clk);

		$display("Covered %0d requests: %0d evictions, %0d victim requests on an empty set,",
			request_count, eviction_count, empty_victims);
		$display("peak of %0d evictable frames, %0d cycles", peak_size, cycles);
		if (fail_count == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule
